// ===== design/scp_pkg.sv =====
// ---------------------------------------------------------------------------
// scp_pkg
// Shared types and constants for the second-chance page replacement block.
// ---------------------------------------------------------------------------
package scp_pkg;

    // default build sizes
    localparam int SLOTS_DEF     = 16;
    localparam int PAGE_BITS_DEF = 16;

    // fixed port field widths
    localparam int PAGE_W      = 16;
    localparam int SLOT_IDX_W  = 4;
    localparam int ACTIVE_W    = 5;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 24;
    localparam int OUT_USER_W  = 2;

    // active slot count after reset
    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

    // bit positions in the result tuser
    localparam int USER_FAULT_BIT = 0;
    localparam int USER_EVICT_BIT = 1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SWEEP,
        ST_LOAD,
        ST_FINISH
    } scp_state_t;

endpackage

// ===== design/second_chance_page_replacement.sv =====
// A hit gives its result once the sequential lookup has compared its slot; a miss runs
// the lookup over every active slot, then the clock-hand sweep (ST_SWEEP), the victim
// load (ST_LOAD) and the result hand-off (ST_FINISH).
// Throughput: one access at a time; the next input transfer can come in the cycle after the
// result is loaded, and a stalled result holds the block until the output register frees.
// Reset (aresetn low, synchronous) clears the used, reference and dirty bits,
// the clock hand and the output valid, and sets active_slots to 16.
// ---------------------------------------------------------------------------
// second_chance_page_replacement
// Enhanced second-chance clock replacement over a small set of frame slots,
// with a sequential page lookup and a one-slot-per-cycle clock sweep.
// ---------------------------------------------------------------------------
module second_chance_page_replacement
    import scp_pkg::*;
#(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int PAGE_BITS = PAGE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write: active_slots
    input  logic                  cfg_wr_en,
    input  logic [ACTIVE_W-1:0]   cfg_wr_data,
    // access stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [15:0] page_number
    input  logic [0:0]            s_tuser,   // [0] is_write
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [3:0] slot_index, [19:4] evicted_page, zero pad
    output logic [OUT_USER_W-1:0] m_tuser    // [0] fault, [1] evicted_valid
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PW     = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;

    // sequencer
    scp_state_t state_reg, state_next;

    // configuration and slot state
    logic [ACTIVE_W-1:0] active_reg;
    logic [SLOTS-1:0]    used_reg;
    logic [SLOTS-1:0]    ref_reg;
    logic [SLOTS-1:0]    dirty_reg;
    logic [SLOT_W-1:0]   hand_reg;
    logic [PW-1:0]       page_mem [SLOTS];
    logic [PW-1:0]       mem_q_reg;

    // current access
    logic [PW-1:0]       page_reg;
    logic                wr_reg;
    logic [SLOT_W-1:0]   scan_idx_reg;
    logic [SLOT_W-1:0]   cmp_idx_reg;
    logic                cmp_vld_reg;
    logic [SLOT_W-1:0]   victim_reg;

    // staged result
    logic                res_fault_reg;
    logic [SLOT_W-1:0]   res_slot_reg;
    logic                res_ev_vld_reg;
    logic [PW-1:0]       res_ev_page_reg;

    // output register
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic [OUT_USER_W-1:0] m_tuser_reg;

    // decoded control
    logic [31:0]       n32;
    logic [SLOT_W-1:0] last_idx;
    logic              in_xfer;
    logic              hit;
    logic              scan_end;
    logic              victim_found;
    logic              out_free;
    logic              out_load;
    logic [SLOT_W-1:0] rd_addr;
    logic [SLOT_W-1:0] hand_adv;
    logic [SLOT_W-1:0] hand_start;

    // clamp the active count and find the last active slot
    always_comb begin
        if (active_reg == '0) begin
            n32 = 32'd1;
        end else if (32'(active_reg) > 32'(SLOTS)) begin
            n32 = 32'(SLOTS);
        end else begin
            n32 = 32'(active_reg);
        end
        last_idx = SLOT_W'(n32 - 32'd1);
    end

    // lookup and sweep decode
    assign in_xfer      = s_tvalid && s_tready;
    assign hit          = (state_reg == ST_SCAN) && cmp_vld_reg && used_reg[cmp_idx_reg]
                          && (mem_q_reg == page_reg);
    assign scan_end     = (state_reg == ST_SCAN) && cmp_vld_reg && (cmp_idx_reg == last_idx)
                          && !hit;
    assign victim_found = !ref_reg[hand_reg] && !dirty_reg[hand_reg];
    assign out_free     = !m_tvalid_reg || m_tready;
    assign hand_adv     = (hand_reg == last_idx) ? '0 : hand_reg + SLOT_W'(1);
    assign hand_start   = (hand_reg > last_idx) ? '0 : hand_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                priority if (hit)  state_next = ST_FINISH;
                else if (scan_end) state_next = ST_SWEEP;
            end
            ST_SWEEP: begin
                if (victim_found) state_next = ST_LOAD;
            end
            ST_LOAD: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_tready = 1'b0;
        out_load = 1'b0;
        rd_addr  = scan_idx_reg;
        unique case (state_reg)
            ST_IDLE:   s_tready = 1'b1;
            ST_SCAN:   rd_addr  = scan_idx_reg;
            ST_SWEEP:  rd_addr  = hand_reg;
            ST_LOAD:   rd_addr  = victim_reg;
            ST_FINISH: out_load = out_free;
            default:   s_tready = 1'b0;
        endcase
    end

    // state register and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            active_reg <= ACTIVE_RESET;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) active_reg <= cfg_wr_data;
        end
    end

    // page store, one read and one write port
    always_ff @(posedge aclk) begin
        mem_q_reg <= page_mem[rd_addr];
        if (state_reg == ST_LOAD) page_mem[victim_reg] <= page_reg;
    end

    // capture the access and step the lookup address
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_vld_reg <= 1'b0;
        end else if (in_xfer) begin
            cmp_vld_reg <= 1'b0;
        end else if (state_reg == ST_SCAN) begin
            cmp_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            page_reg     <= s_tdata[PW-1:0];
            wr_reg       <= s_tuser[0];
            scan_idx_reg <= '0;
        end else if (state_reg == ST_SCAN) begin
            cmp_idx_reg <= scan_idx_reg;
            if (scan_idx_reg != last_idx) scan_idx_reg <= scan_idx_reg + SLOT_W'(1);
        end
    end

    // slot flags and clock hand
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg  <= '0;
            ref_reg   <= '0;
            dirty_reg <= '0;
            hand_reg  <= '0;
        end else begin
            if (hit) begin
                ref_reg[cmp_idx_reg]   <= 1'b1;
                dirty_reg[cmp_idx_reg] <= dirty_reg[cmp_idx_reg] | wr_reg;
            end
            if (scan_end) hand_reg <= hand_start;
            if (state_reg == ST_SWEEP) begin
                priority if (ref_reg[hand_reg]) ref_reg[hand_reg]   <= 1'b0;
                else if (dirty_reg[hand_reg])   dirty_reg[hand_reg] <= 1'b0;
                hand_reg <= hand_adv;
            end
            if (state_reg == ST_LOAD) begin
                used_reg[victim_reg]  <= 1'b1;
                ref_reg[victim_reg]   <= 1'b1;
                dirty_reg[victim_reg] <= wr_reg;
            end
        end
    end

    // victim slot and staged result
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_SWEEP) && victim_found) victim_reg <= hand_reg;
        if (hit) begin
            res_fault_reg   <= 1'b0;
            res_slot_reg    <= cmp_idx_reg;
            res_ev_vld_reg  <= 1'b0;
            res_ev_page_reg <= '0;
        end else if (state_reg == ST_LOAD) begin
            res_fault_reg   <= 1'b1;
            res_slot_reg    <= victim_reg;
            res_ev_vld_reg  <= used_reg[victim_reg];
            res_ev_page_reg <= used_reg[victim_reg] ? mem_q_reg : '0;
        end
    end

    // pack the result fields
    logic [SLOT_W+SLOT_IDX_W-1:0] slot_wide;
    logic [PW+PAGE_W-1:0]         page_wide;
    logic [OUT_DATA_W-1:0]        data_pack;

    always_comb begin
        slot_wide = {{SLOT_IDX_W{1'b0}}, res_slot_reg};
        page_wide = {{PAGE_W{1'b0}}, res_ev_page_reg};
        data_pack = '0;
        data_pack[SLOT_IDX_W-1:0]               = slot_wide[SLOT_IDX_W-1:0];
        data_pack[SLOT_IDX_W+PAGE_W-1:SLOT_IDX_W] = page_wide[PAGE_W-1:0];
    end

    // output register, freed by a result transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg                 <= data_pack;
            m_tuser_reg[USER_FAULT_BIT] <= res_fault_reg;
            m_tuser_reg[USER_EVICT_BIT] <= res_ev_vld_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== design/scp_checker.sv =====
// ---------------------------------------------------------------------------
// scp_checker
// Port-level checks on the page replacement block, bound to the top level.
// ---------------------------------------------------------------------------
module scp_checker
    import scp_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [OUT_USER_W-1:0] m_tuser
);

    // no result is shown in the cycle after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // one access at a time: not ready right after an input transfer
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second access taken while one is in progress");

    // a hit never reports an eviction
    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[USER_FAULT_BIT]) |-> !m_tuser[USER_EVICT_BIT])
        else $error("eviction reported on a hit");

    // evicted page is zero when nothing was evicted
    a_evict_page_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[USER_EVICT_BIT]) |-> (m_tdata[19:4] == 16'd0))
        else $error("evicted page not zero without eviction");

    // a stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind second_chance_page_replacement scp_checker u_scp_checker (.*);

// ===== tb/second_chance_page_replacement_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// second_chance_page_replacement_tb
// Self-checking bench for the second-chance page replacement block. Page
// accesses are sent over the input stream with random gaps and the results
// are taken with random back-pressure. A behavioural copy of the frame table
// and clock hand predicts fault, slot and eviction for every accepted access.
// The active slot count is changed between phases while the block is idle.
// ---------------------------------------------------------------------------
module second_chance_page_replacement_tb;
    import scp_pkg::*;

    localparam int NUM_SLOTS   = SLOTS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_PRINTS  = 40;

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic              wr;
    } page_access_t;

    typedef struct packed {
        logic                  fault;
        logic [SLOT_IDX_W-1:0] slot;
        logic                  ev_valid;
        logic [PAGE_W-1:0]     ev_page;
    } access_result_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [ACTIVE_W-1:0]   cfg_wr_data = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata     = '0;
    logic [0:0]            s_tuser     = '0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;

    // shadow frame table
    logic [PAGE_W-1:0]   shadow_page [NUM_SLOTS];
    bit                  shadow_used [NUM_SLOTS];
    bit                  shadow_ref  [NUM_SLOTS];
    bit                  shadow_dirty[NUM_SLOTS];
    int                  shadow_hand;
    logic [ACTIVE_W-1:0] shadow_active;

    page_access_t   pending_accesses[$];
    access_result_t expected_results[$];

    int  queued_cnt    = 0;
    int  accepted_cnt  = 0;
    int  mismatch_cnt  = 0;
    int  cycle_cnt     = 0;
    int  gap_left      = 0;
    int  stall_left    = 0;
    bit  s_taken       = 1'b0;
    bit  m_taken       = 1'b0;
    bit  sender_idles  = 1'b1;
    bit  receiver_idles = 1'b1;

    logic [PAGE_W-1:0] page_pool[24];

    second_chance_page_replacement u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #5 aclk = ~aclk;

    // clock sweep over the shadow table for one access
    function automatic access_result_t replace_page(logic [PAGE_W-1:0] page, logic wr);
        access_result_t res;
        int n;
        int i;
        int h;
        int hit_slot;
        int victim;
        res = '0;
        n = (shadow_active == 0) ? 1 :
            (shadow_active > NUM_SLOTS) ? NUM_SLOTS : int'(shadow_active);
        hit_slot = -1;
        for (i = n - 1; i >= 0; i--) begin
            if (shadow_used[i] && shadow_page[i] == page) begin
                hit_slot = i;
            end
        end
        if (hit_slot >= 0) begin
            shadow_ref[hit_slot]   = 1'b1;
            shadow_dirty[hit_slot] = shadow_dirty[hit_slot] | wr;
            res.slot = SLOT_IDX_W'(hit_slot);
            return res;
        end
        // sweep from the hand, restarting at zero if the count shrank past it
        h = (shadow_hand >= n) ? 0 : shadow_hand;
        victim = -1;
        while (victim < 0) begin
            if (shadow_ref[h]) begin
                shadow_ref[h] = 1'b0;
            end else if (shadow_dirty[h]) begin
                shadow_dirty[h] = 1'b0;
            end else begin
                victim = h;
            end
            h = (h + 1 >= n) ? 0 : h + 1;
        end
        shadow_hand = h;
        res.fault = 1'b1;
        res.slot  = SLOT_IDX_W'(victim);
        if (shadow_used[victim]) begin
            res.ev_valid = 1'b1;
            res.ev_page  = shadow_page[victim];
        end
        shadow_page[victim]  = page;
        shadow_used[victim]  = 1'b1;
        shadow_ref[victim]   = 1'b1;
        shadow_dirty[victim] = wr;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (mismatch_cnt < MAX_PRINTS) begin
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h",
                     $realtime, what, got, want);
        end
        mismatch_cnt++;
    endtask

    function automatic int draw_wait(bit enabled);
        return enabled ? int'($urandom_range(0, 6)) : 0;
    endfunction

    // sample transfers on both streams and config writes
    always @(posedge aclk) begin
        access_result_t want;
        cycle_cnt <= cycle_cnt + 1;
        if (!aresetn) begin
            s_taken <= 1'b0;
            m_taken <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                shadow_active = cfg_wr_data;
            end
            // result transfer against the oldest prediction
            m_taken <= m_tvalid && m_tready;
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", m_tdata, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_tuser[USER_FAULT_BIT] !== want.fault)
                        report_mismatch("fault", m_tuser[USER_FAULT_BIT], want.fault);
                    if (m_tdata[SLOT_IDX_W-1:0] !== want.slot)
                        report_mismatch("slot_index", m_tdata[SLOT_IDX_W-1:0], want.slot);
                    if (m_tuser[USER_EVICT_BIT] !== want.ev_valid)
                        report_mismatch("evicted_valid", m_tuser[USER_EVICT_BIT],
                                        want.ev_valid);
                    if (m_tdata[SLOT_IDX_W +: PAGE_W] !== want.ev_page)
                        report_mismatch("evicted_page", m_tdata[SLOT_IDX_W +: PAGE_W],
                                        want.ev_page);
                    if (m_tdata[OUT_DATA_W-1:SLOT_IDX_W+PAGE_W] !== '0)
                        report_mismatch("tdata padding",
                                        m_tdata[OUT_DATA_W-1:SLOT_IDX_W+PAGE_W], 0);
                end
            end
            // access transfer feeds the predictor
            s_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                expected_results.push_back(replace_page(s_tdata[PAGE_W-1:0], s_tuser[0]));
                accepted_cnt <= accepted_cnt + 1;
            end
        end
    end

    // access driver
    always @(negedge aclk) begin
        page_access_t acc;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_taken) begin
            if (s_taken) begin
                gap_left = draw_wait(sender_idles);
            end
            if (gap_left > 0) begin
                s_tvalid <= 1'b0;
                gap_left--;
            end else if (pending_accesses.size() != 0) begin
                acc = pending_accesses.pop_front();
                s_tdata  <= acc.page;
                s_tuser  <= acc.wr;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result back-pressure
    always @(negedge aclk) begin
        if (m_taken) begin
            stall_left = draw_wait(receiver_idles);
        end
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // run limit
    always @(posedge aclk) begin
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic queue_access(input logic [PAGE_W-1:0] page, input logic wr);
        page_access_t acc;
        acc.page = page;
        acc.wr   = wr;
        pending_accesses.push_back(acc);
        queued_cnt++;
    endtask

    task automatic wait_drained();
        while (accepted_cnt != queued_cnt || expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_active_slots(input logic [ACTIVE_W-1:0] value);
        @(negedge aclk);
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // phases of random accesses drawn mostly from a small working set
    task automatic random_phase(input logic [ACTIVE_W-1:0] active, input int count);
        int k;
        int ws;
        int pick;
        logic [PAGE_W-1:0] page;
        set_active_slots(active);
        sender_idles   = ($urandom_range(0, 3) != 0);
        receiver_idles = ($urandom_range(0, 3) != 0);
        ws = $urandom_range(1, 24);
        for (k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                page = PAGE_W'($urandom);
            end else begin
                if (pick < 15) begin
                    page_pool[$urandom_range(0, 23)] = PAGE_W'($urandom);
                end
                page = page_pool[$urandom_range(0, ws - 1)];
            end
            queue_access(page, ($urandom_range(0, 9) < 4));
        end
        wait_drained();
    endtask

    initial begin
        int k;
        shadow_active = ACTIVE_RESET;
        shadow_hand   = 0;
        for (k = 0; k < NUM_SLOTS; k++) begin
            shadow_page[k]  = '0;
            shadow_used[k]  = 1'b0;
            shadow_ref[k]   = 1'b0;
            shadow_dirty[k] = 1'b0;
        end
        for (k = 0; k < 24; k++) begin
            page_pool[k] = PAGE_W'($urandom);
        end
        page_pool[0] = '0;
        page_pool[1] = '1;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: fill all slots, hit, then a miss that sweeps past every slot before it finds a victim
        queue_access(16'h0000, 1'b0);
        queue_access(16'hFFFF, 1'b1);
        queue_access(16'h0000, 1'b1);
        for (k = 0; k < 14; k++) begin
            queue_access(16'h0100 + PAGE_W'(k), 1'b0);
        end
        queue_access(16'h0200, 1'b0);
        queue_access(16'h0000, 1'b0);
        queue_access(16'hAAAA, 1'b1);
        queue_access(16'h5555, 1'b0);
        wait_drained();

        // shrink below the hand, reload a page that sits in an ignored slot
        set_active_slots(5'd2);
        queue_access(16'h0105, 1'b0);
        queue_access(16'h1234, 1'b1);
        wait_drained();

        // zero acts as a single slot
        set_active_slots(5'd0);
        queue_access(16'h0007, 1'b1);
        queue_access(16'h0008, 1'b0);
        wait_drained();

        // above the slot count acts as all slots; duplicate hits the lowest slot
        set_active_slots(5'd31);
        queue_access(16'h0105, 1'b1);
        queue_access(16'h0106, 1'b0);
        wait_drained();

        // random phases over a spread of active counts
        random_phase(5'd16, 110);
        random_phase(5'd1,  80);
        random_phase(5'd4,  100);
        random_phase(5'd31, 110);
        random_phase(5'd0,  60);
        random_phase(5'd9,  110);
        random_phase(5'd2,  90);
        random_phase(5'd16, 120);
        random_phase(5'd17, 100);
        random_phase(5'd7,  100);
        random_phase(5'd12, 110);
        random_phase(5'd3,  90);
        random_phase(5'd16, 140);

        repeat (60) @(posedge aclk);
        if (mismatch_cnt == 0 && expected_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
